@@ rtl/ctw_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ctw_pkg;

	// wheel geometry
	localparam int MAX_SLOTS     = 16;
	localparam int SLOT_CAPACITY = 16;
	localparam int MAX_IDS       = 1024;

	// field widths
	localparam int SOCK_W = 10;
	localparam int WS_W   = 5;
	localparam int SLOT_W = $clog2(MAX_SLOTS);
	localparam int POS_W  = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
	localparam int CNT_W  = $clog2(SLOT_CAPACITY + 1);
	localparam int IDX_W  = $clog2(MAX_IDS);

	// slot entry store
	localparam int ENT_DEPTH = MAX_SLOTS * SLOT_CAPACITY;
	localparam int ENT_W     = $clog2(ENT_DEPTH);

	localparam logic [WS_W-1:0] WS_RESET = WS_W'(16);

	typedef enum logic [1:0] {
		REQ_ARM     = 2'd0,
		REQ_CANCEL  = 2'd1,
		REQ_REFRESH = 2'd2,
		REQ_TICK    = 2'd3
	} req_kind_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_ARMED     = 2'd1,
		STAT_NOT_ARMED = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ARM,
		S_CANCEL,
		S_MOVE,
		S_TICK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]        req_type;
		logic [SOCK_W-1:0] socket_id;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [SOCK_W-1:0] expired_socket;
		logic              expired_valid;
		logic              last;
	} rsp_t;

endpackage

`default_nettype wire

@@ rtl/ctw_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ctw_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/connection_timeout_wheel.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Arm: S_ARM follows acceptance; busy is high only in the cycle after the accepting edge.
// Cancel: S_CANCEL, then S_MOVE when the slot's last entry moves into the freed position.
// Refresh: the cancel states followed by S_ARM. Tick: S_TICK, then S_EMIT once per
// expiring id, one result per cycle. The receiver cannot stall.
// After reset the armed-flag memory is swept, one id per cycle; busy until all 1024 are clear.

module connection_timeout_wheel (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  ctw_pkg::req_t           req,
	input  logic                    cfg_we,
	input  logic [ctw_pkg::WS_W-1:0] cfg_wdata,
	output logic                    result_valid,
	output ctw_pkg::rsp_t           result
);

	import ctw_pkg::*;

	state_t state_q, state_d;

	logic [WS_W-1:0]   ws_q;
	logic [SLOT_W-1:0] cur_q;
	logic [CNT_W-1:0]  cnt_q [MAX_SLOTS];
	req_t              req_q;
	logic [SLOT_W-1:0] s_q;
	logic [POS_W-1:0]  p_q;
	logic [POS_W-1:0]  k_q;
	logic [CNT_W-1:0]  n_q;
	logic [IDX_W-1:0]  clr_q;
	rsp_t              out_q;
	logic              out_valid_q;

	// memory ports
	logic              arm_we, arm_wdata, arm_rdata, id_re;
	logic [IDX_W-1:0]  arm_waddr, id_raddr;
	logic              slot_we;
	logic [IDX_W-1:0]  slot_waddr;
	logic [SLOT_W-1:0] slot_wdata, slot_rdata;
	logic              pos_we;
	logic [IDX_W-1:0]  pos_waddr;
	logic [POS_W-1:0]  pos_wdata, pos_rdata;
	logic              ent_we, ent_re;
	logic [ENT_W-1:0]  ent_waddr, ent_raddr;
	logic [SOCK_W-1:0] ent_wdata, ent_rdata;

	// sequencer controls
	logic              ld_req, ld_sp, ld_tick, k_inc, clr_inc;
	logic              cur_we;
	logic [SLOT_W-1:0] cur_d;
	logic              cnt_we;
	logic [SLOT_W-1:0] cnt_widx, cnt_ridx;
	logic [CNT_W-1:0]  cnt_wd, cnt_rd, cnt_dec;
	logic              out_we;
	rsp_t              out_d;

	logic [SLOT_W:0]   siu, cur_nxt;
	logic [SLOT_W-1:0] tgt;
	logic [IDX_W-1:0]  id_ix;
	logic              refresh, id_bad, tick_last, armed_now;

	function automatic logic [ENT_W-1:0] ent_addr(input logic [SLOT_W-1:0] s,
			input logic [POS_W-1:0] p);
		return ENT_W'(s) * ENT_W'(SLOT_CAPACITY) + ENT_W'(p);
	endfunction

	ctw_ram #(.DEPTH(MAX_IDS), .WIDTH(1)) u_armed (
		.clk(clk), .we(arm_we), .waddr(arm_waddr), .wdata(arm_wdata),
		.re(id_re), .raddr(id_raddr), .rdata(arm_rdata)
	);

	ctw_ram #(.DEPTH(MAX_IDS), .WIDTH(SLOT_W)) u_id_slot (
		.clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
		.re(id_re), .raddr(id_raddr), .rdata(slot_rdata)
	);

	ctw_ram #(.DEPTH(MAX_IDS), .WIDTH(POS_W)) u_id_pos (
		.clk(clk), .we(pos_we), .waddr(pos_waddr), .wdata(pos_wdata),
		.re(id_re), .raddr(id_raddr), .rdata(pos_rdata)
	);

	ctw_ram #(.DEPTH(ENT_DEPTH), .WIDTH(SOCK_W)) u_entries (
		.clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
		.re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
	);

	// effective wheel size, arm target and next index
	always_comb begin
		if (ws_q == '0) begin
			siu = (SLOT_W+1)'(1);
		end else if (int'(ws_q) > MAX_SLOTS) begin
			siu = (SLOT_W+1)'(MAX_SLOTS);
		end else begin
			siu = (SLOT_W+1)'(ws_q);
		end
		tgt     = (cur_q != '0) ? cur_q - SLOT_W'(1) : SLOT_W'(siu - (SLOT_W+1)'(1));
		cur_nxt = {1'b0, cur_q} + (SLOT_W+1)'(1);
	end

	assign id_ix     = IDX_W'(req_q.socket_id);
	assign refresh   = (req_q.req_type == REQ_REFRESH);
	assign id_bad    = (int'(req.socket_id) >= MAX_IDS);
	assign armed_now = arm_rdata & ~refresh;
	assign tick_last = ((CNT_W'(k_q) + CNT_W'(1)) == n_q);
	assign id_raddr  = IDX_W'(req.socket_id);

	// slot fill count read port
	always_comb begin
		unique case (state_q)
			S_ARM:    cnt_ridx = tgt;
			S_CANCEL: cnt_ridx = slot_rdata;
			default:  cnt_ridx = cur_q;
		endcase
	end
	assign cnt_rd  = cnt_q[cnt_ridx];
	assign cnt_dec = cnt_rd - CNT_W'(1);

	// next state and datapath controls
	always_comb begin
		state_d    = state_q;
		ld_req     = 1'b0;
		ld_sp      = 1'b0;
		ld_tick    = 1'b0;
		k_inc      = 1'b0;
		clr_inc    = 1'b0;
		cur_we     = 1'b0;
		cur_d      = '0;
		cnt_we     = 1'b0;
		cnt_widx   = '0;
		cnt_wd     = '0;
		id_re      = 1'b0;
		arm_we     = 1'b0;
		arm_waddr  = id_ix;
		arm_wdata  = 1'b0;
		slot_we    = 1'b0;
		slot_waddr = id_ix;
		slot_wdata = tgt;
		pos_we     = 1'b0;
		pos_waddr  = id_ix;
		pos_wdata  = POS_W'(cnt_rd);
		ent_we     = 1'b0;
		ent_waddr  = ent_addr(tgt, POS_W'(cnt_rd));
		ent_wdata  = req_q.socket_id;
		ent_re     = 1'b0;
		ent_raddr  = ent_addr(s_q, k_q + POS_W'(1));
		out_we     = 1'b0;
		out_d      = '{status: STAT_OK, expired_socket: '0, expired_valid: 1'b0,
			last: 1'b1};

		unique case (state_q)
			// sweep the armed flags after reset
			S_CLEAR: begin
				arm_we    = 1'b1;
				arm_waddr = clr_q;
				clr_inc   = 1'b1;
				if (clr_q == IDX_W'(MAX_IDS - 1)) begin
					state_d = S_IDLE;
				end
			end

			S_IDLE: begin
				if (start) begin
					ld_req = 1'b1;
					if (req.req_type == REQ_TICK) begin
						state_d = S_TICK;
					end else if (id_bad) begin
						out_we       = 1'b1;
						out_d.status = STAT_NOT_ARMED;
					end else begin
						id_re   = 1'b1;
						state_d = (req.req_type == REQ_ARM) ? S_ARM : S_CANCEL;
					end
				end
			end

			// append to the slot behind the index
			S_ARM: begin
				out_we  = 1'b1;
				state_d = S_IDLE;
				if (armed_now) begin
					out_d.status = STAT_ARMED;
				end else if (cnt_rd >= CNT_W'(SLOT_CAPACITY)) begin
					out_d.status = STAT_FULL;
				end else begin
					arm_we    = 1'b1;
					arm_wdata = 1'b1;
					slot_we   = 1'b1;
					pos_we    = 1'b1;
					ent_we    = 1'b1;
					cnt_we    = 1'b1;
					cnt_widx  = tgt;
					cnt_wd    = cnt_rd + CNT_W'(1);
				end
			end

			// disarm, shrink the slot, fetch its last entry if it must move
			S_CANCEL: begin
				if (!arm_rdata) begin
					if (refresh) begin
						state_d = S_ARM;
					end else begin
						out_we       = 1'b1;
						out_d.status = STAT_NOT_ARMED;
						state_d      = S_IDLE;
					end
				end else begin
					arm_we = 1'b1;
					if (cnt_rd != '0) begin
						cnt_we   = 1'b1;
						cnt_widx = slot_rdata;
						cnt_wd   = cnt_dec;
					end
					if (cnt_rd != '0 && CNT_W'(pos_rdata) < cnt_dec) begin
						ent_re    = 1'b1;
						ent_raddr = ent_addr(slot_rdata, POS_W'(cnt_dec));
						ld_sp     = 1'b1;
						state_d   = S_MOVE;
					end else if (refresh) begin
						state_d = S_ARM;
					end else begin
						out_we  = 1'b1;
						state_d = S_IDLE;
					end
				end
			end

			// last entry fills the hole
			S_MOVE: begin
				ent_we    = 1'b1;
				ent_waddr = ent_addr(s_q, p_q);
				ent_wdata = ent_rdata;
				pos_we    = 1'b1;
				pos_waddr = IDX_W'(ent_rdata);
				pos_wdata = p_q;
				if (refresh) begin
					state_d = S_ARM;
				end else begin
					out_we  = 1'b1;
					state_d = S_IDLE;
				end
			end

			// advance the index, start the slot walk
			S_TICK: begin
				cur_we = 1'b1;
				cur_d  = (cur_nxt >= siu) ? '0 : SLOT_W'(cur_nxt);
				if (cnt_rd == '0) begin
					out_we  = 1'b1;
					state_d = S_IDLE;
				end else begin
					ld_tick   = 1'b1;
					ent_re    = 1'b1;
					ent_raddr = ent_addr(cur_q, '0);
					state_d   = S_EMIT;
				end
			end

			// one expired id per cycle
			S_EMIT: begin
				out_we               = 1'b1;
				out_d.expired_socket = ent_rdata;
				out_d.expired_valid  = 1'b1;
				out_d.last           = tick_last;
				arm_we               = 1'b1;
				arm_waddr            = IDX_W'(ent_rdata);
				if (tick_last) begin
					cnt_we   = 1'b1;
					cnt_widx = s_q;
					state_d  = S_IDLE;
				end else begin
					k_inc  = 1'b1;
					ent_re = 1'b1;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q        <= WS_RESET;
			cur_q       <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < MAX_SLOTS; i++) begin
				cnt_q[i] <= '0;
			end
		end else begin
			out_valid_q <= out_we;
			if (cfg_we) begin
				ws_q <= cfg_wdata;
			end
			if (cur_we) begin
				cur_q <= cur_d;
			end
			if (clr_inc) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cnt_we) begin
				cnt_q[cnt_widx] <= cnt_wd;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (ld_req) begin
			req_q <= req;
		end
		if (ld_sp) begin
			s_q <= slot_rdata;
			p_q <= pos_rdata;
		end
		if (ld_tick) begin
			s_q <= cur_q;
			n_q <= cnt_rd;
			k_q <= '0;
		end else if (k_inc) begin
			k_q <= k_q + POS_W'(1);
		end
		if (out_we) begin
			out_q <= out_d;
		end
	end

	assign busy         = (state_q != S_IDLE);
	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

`default_nettype wire

@@ verif/tb_connection_timeout_wheel.sv @@
`timescale 1ns / 1ps

module tb_connection_timeout_wheel;
	import ctw_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int NUM_ROWS = 22;
	localparam int NUM_PHASES = 7;

	// single-result patterns that can be read straight off the spec
	// (an empty tick looks exactly like a successful arm)
	localparam rsp_t RSP_OK        = '{STAT_OK, 10'd0, 1'b0, 1'b1};
	localparam rsp_t RSP_ARMED     = '{STAT_ARMED, 10'd0, 1'b0, 1'b1};
	localparam rsp_t RSP_NOT_ARMED = '{STAT_NOT_ARMED, 10'd0, 1'b0, 1'b1};

	typedef struct {
		req_kind_t        kind;
		logic [SOCK_W-1:0] id;
		bit               known;
		rsp_t             rsp;
	} dir_row_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             start = 1'b0;
	logic             busy;
	req_t             req = '0;
	logic             cfg_we = 1'b0;
	logic [WS_W-1:0]  cfg_wdata = '0;
	logic             result_valid;
	rsp_t             result;

	// side info travelling with the request being offered
	bit               row_known = 1'b0;
	rsp_t             row_rsp = '0;

	// wheel shadow state
	logic [WS_W-1:0]  wheel_cfg;
	int               cur_slot;
	int               slot_cnt [MAX_SLOTS];
	logic [SOCK_W-1:0] slot_ent [MAX_SLOTS][SLOT_CAPACITY];
	bit               id_armed [MAX_IDS];
	int               id_slot [MAX_IDS];
	int               id_pos [MAX_IDS];

	rsp_t             expiry_queue [$];
	int               mismatches = 0;
	int               stall_cnt = 0;
	logic [SOCK_W-1:0] id_pool [32];

	dir_row_t dir_rows [NUM_ROWS] = '{
		'{REQ_TICK,    10'd1023, 1'b1, RSP_OK},
		'{REQ_CANCEL,  10'd7,    1'b1, RSP_NOT_ARMED},
		'{REQ_ARM,     10'd0,    1'b1, RSP_OK},
		'{REQ_ARM,     10'd0,    1'b1, RSP_ARMED},
		'{REQ_ARM,     10'd1023, 1'b1, RSP_OK},
		'{REQ_ARM,     10'd512,  1'b0, RSP_OK},
		'{REQ_ARM,     10'd341,  1'b0, RSP_OK},
		'{REQ_ARM,     10'd682,  1'b0, RSP_OK},
		'{REQ_CANCEL,  10'd0,    1'b0, RSP_OK},
		'{REQ_CANCEL,  10'd682,  1'b0, RSP_OK},
		'{REQ_REFRESH, 10'd1023, 1'b0, RSP_OK},
		'{REQ_REFRESH, 10'd100,  1'b0, RSP_OK},
		'{REQ_TICK,    10'd0,    1'b0, RSP_OK},
		'{REQ_TICK,    10'd0,    1'b0, RSP_OK},
		'{REQ_ARM,     10'd5,    1'b0, RSP_OK},
		'{REQ_ARM,     10'd6,    1'b0, RSP_OK},
		'{REQ_CANCEL,  10'd6,    1'b0, RSP_OK},
		'{REQ_TICK,    10'd1023, 1'b0, RSP_OK},
		'{REQ_TICK,    10'd0,    1'b0, RSP_OK},
		'{REQ_CANCEL,  10'd5,    1'b0, RSP_OK},
		'{REQ_REFRESH, 10'd1023, 1'b0, RSP_OK},
		'{REQ_TICK,    10'd341,  1'b0, RSP_OK}
	};

	// per phase: wheel size, sender idle percent, tick percent, item count
	int ph_wheel [NUM_PHASES] = '{16, 1, 0, 31, 3, 16, 2};
	int ph_idle  [NUM_PHASES] = '{0, 79, 0, 38, 79, 0, 38};
	int ph_tick  [NUM_PHASES] = '{15, 20, 10, 3, 25, 2, 30};
	int ph_items [NUM_PHASES] = '{50, 40, 40, 50, 40, 50, 50};

	connection_timeout_wheel DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic rsp_t mk_rsp(status_t st, logic [SOCK_W-1:0] sock, logic v, logic l);
		rsp_t r;
		r.status = st;
		r.expired_socket = sock;
		r.expired_valid = v;
		r.last = l;
		return r;
	endfunction

	// append one expected result at the tail of the scoreboard
	function automatic void add_expect(rsp_t r);
		expiry_queue.insert(expiry_queue.size(), r);
	endfunction

	// 0 behaves as one slot, anything above the wheel as the full wheel
	function automatic int slots_used();
		if (wheel_cfg == 0)
			return 1;
		if (int'(wheel_cfg) > MAX_SLOTS)
			return MAX_SLOTS;
		return int'(wheel_cfg);
	endfunction

	// place id in the slot just behind the current index
	function automatic status_t arm_id(logic [SOCK_W-1:0] id);
		int tgt, n;
		if (id_armed[id])
			return STAT_ARMED;
		tgt = ((cur_slot != 0) ? cur_slot : slots_used()) - 1;
		tgt = tgt % MAX_SLOTS;
		n = slot_cnt[tgt];
		if (n >= SLOT_CAPACITY)
			return STAT_FULL;
		slot_ent[tgt][n] = id;
		slot_cnt[tgt] = n + 1;
		id_armed[id] = 1'b1;
		id_slot[id] = tgt;
		id_pos[id] = n;
		return STAT_OK;
	endfunction

	// remove id, filling the hole with the slot's last entry
	function automatic status_t cancel_id(logic [SOCK_W-1:0] id);
		int s, p, n;
		logic [SOCK_W-1:0] moved;
		if (!id_armed[id])
			return STAT_NOT_ARMED;
		id_armed[id] = 1'b0;
		s = id_slot[id] % MAX_SLOTS;
		p = id_pos[id];
		n = slot_cnt[s];
		if (n == 0)
			return STAT_OK;
		n = n - 1;
		if (p < n) begin
			moved = slot_ent[s][n];
			slot_ent[s][p] = moved;
			id_pos[moved] = p;
		end
		slot_cnt[s] = n;
		return STAT_OK;
	endfunction

	// advance the shadow wheel by one request, queueing what it emits
	function automatic void predict_wheel(req_t r);
		int s, n, nxt;
		status_t st;
		logic [SOCK_W-1:0] e;
		if (req_kind_t'(r.req_type) == REQ_TICK) begin
			s = cur_slot % MAX_SLOTS;
			n = slot_cnt[s];
			nxt = s + 1;
			if (nxt >= slots_used())
				nxt = 0;
			cur_slot = nxt;
			if (n == 0) begin
				add_expect(mk_rsp(STAT_OK, '0, 1'b0, 1'b1));
			end else begin
				for (int k = 0; k < n; k++) begin
					e = slot_ent[s][k];
					id_armed[e] = 1'b0;
					add_expect(mk_rsp(STAT_OK, e, 1'b1, (k == n - 1)));
				end
				slot_cnt[s] = 0;
			end
		end else begin
			case (req_kind_t'(r.req_type))
				REQ_ARM: begin
					st = arm_id(r.socket_id);
				end
				REQ_CANCEL: begin
					st = cancel_id(r.socket_id);
				end
				default: begin
					void'(cancel_id(r.socket_id));
					st = arm_id(r.socket_id);
				end
			endcase
			add_expect(mk_rsp(st, '0, 1'b0, 1'b1));
		end
	endfunction

	// result check, config shadow, prediction on each accepted transfer
	always @(posedge clk) begin
		rsp_t want;
		int n0;
		if (arst_n) begin
			if (result_valid) begin
				if (expiry_queue.size() == 0) begin
					$display("%0t: expected none, got %0d/%0d/%0b/%0b", $time,
						result.status, result.expired_socket, result.expired_valid,
						result.last);
					mismatches++;
				end else begin
					want = expiry_queue.pop_front();
					if (result !== want) begin
						$display("%0t: expected %0d/%0d/%0b/%0b, got %0d/%0d/%0b/%0b",
							$time, want.status, want.expired_socket, want.expired_valid,
							want.last, result.status, result.expired_socket,
							result.expired_valid, result.last);
						mismatches++;
					end
				end
			end
			if (cfg_we)
				wheel_cfg = cfg_wdata;
			if (start && !busy) begin
				n0 = expiry_queue.size();
				predict_wheel(req);
				if (row_known)
					expiry_queue[n0] = row_rsp;
			end
		end
	end

	// watchdog on cycles with no transfer of any kind
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || result_valid || cfg_we)
				stall_cnt <= 0;
			else
				stall_cnt <= stall_cnt + 1;
			if (stall_cnt >= STALL_LIMIT) begin
				$display("connection_timeout_wheel: mismatch");
				$finish;
			end
		end
	end

	// offer one request and hold it until the block takes it
	task automatic send_req(req_t r, bit known, rsp_t ref_rsp);
		start <= 1'b1;
		req <= r;
		row_known <= known;
		row_rsp <= ref_rsp;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic idle_gap(int pct);
		if ($urandom_range(99) < pct) begin
			start <= 1'b0;
			row_known <= 1'b0;
			req <= req_t'($urandom);
			repeat ($urandom_range(1, 12))
				@(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		row_known <= 1'b0;
		@(posedge clk);
		while (expiry_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_wheel(int v);
		wait_drained();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		while (busy)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v[WS_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		req_t r;
		int pick;
		wheel_cfg = WS_RESET;
		cur_slot = 0;
		for (int i = 0; i < MAX_SLOTS; i++)
			slot_cnt[i] = 0;
		for (int i = 0; i < MAX_IDS; i++)
			id_armed[i] = 1'b0;
		for (int i = 0; i < 32; i++)
			id_pool[i] = SOCK_W'($urandom_range(1023));

		repeat (10)
			@(posedge clk);
		arst_n <= 1'b1;

		// directed rows on a two-slot wheel
		set_wheel(2);
		for (int i = 0; i < NUM_ROWS; i++) begin
			r.req_type = dir_rows[i].kind;
			r.socket_id = dir_rows[i].id;
			send_req(r, dir_rows[i].known, dir_rows[i].rsp);
			idle_gap(38);
		end

		// random phases; ids mostly drawn from a small recent pool so that
		// cancel and refresh usually hit armed entries
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_wheel(ph_wheel[p]);
			for (int i = 0; i < ph_items[p]; i++) begin
				if ($urandom_range(39) == 0)
					wait_drained();
				if ($urandom_range(99) < ph_tick[p]) begin
					r.req_type = REQ_TICK;
					r.socket_id = SOCK_W'($urandom_range(1023));
				end else begin
					pick = $urandom_range(99);
					if (pick < 45)
						r.req_type = REQ_ARM;
					else if (pick < 70)
						r.req_type = REQ_CANCEL;
					else
						r.req_type = REQ_REFRESH;
					if ($urandom_range(99) < 60)
						r.socket_id = id_pool[5'($urandom_range(31))];
					else
						r.socket_id = SOCK_W'($urandom_range(1023));
					id_pool[5'($urandom_range(31))] = r.socket_id;
				end
				send_req(r, 1'b0, RSP_OK);
				idle_gap(ph_idle[p]);
			end
		end

		wait_drained();
		repeat (40)
			@(posedge clk);
		if (mismatches == 0)
			$display("connection_timeout_wheel: match");
		else
			$display("connection_timeout_wheel: mismatch");
		$finish;
	end

endmodule
